/* rtl/core/block_average_downsampler_defines.svh */
// ----------------------------------------------------------------------------
// Block average downsampler assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`define BLOCK_AVERAGE_DOWNSAMPLER_DEFINES_SVH
`ifndef SYNTHESIS
`define BAD_ASSERT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BAD_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BAD_ASSERT(name, clk, rstn, ante, cons)
`define BAD_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/bad_pkg.sv */
// ----------------------------------------------------------------------------
// Block average downsampler package
// Register map, field widths and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bad_pkg;

  localparam int SampleW = 32;
  localparam int ColsW   = 13;
  localparam int RowsW   = 16;
  localparam int FactW   = 5;

  localparam logic [1:0] REG_IMAGE_COLS = 2'd0;
  localparam logic [1:0] REG_IMAGE_ROWS = 2'd1;
  localparam logic [1:0] REG_ROW_FACTOR = 2'd2;
  localparam logic [1:0] REG_COL_FACTOR = 2'd3;

  typedef struct packed {
    logic step;
    logic merge;
    logic div_start;
    logic out_load;
  } bad_cmd_t;

  typedef struct packed {
    logic colend;
    logic last_row;
    logic div_done;
    logic out_free;
  } bad_status_t;

endpackage

/* rtl/core/bad_div.sv */
// ----------------------------------------------------------------------------
// Block average divider
// Signed by unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bad_div import bad_pkg::*; #(
  parameter int DW = 40,
  parameter int VW = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] dividend_i,
  input  logic [VW-1:0]        divisor_i,
  output logic                 done_o,
  output logic [SampleW-1:0]   quotient_o
);

  localparam int NW = $clog2(DW + 1);

  logic          run_q, done_q, neg_q;
  logic [NW-1:0] cnt_q;
  logic [VW-1:0] rem_q, div_q;
  logic [DW-1:0] quo_q;
  logic [VW:0]   shifted;
  logic [VW+1:0] diff;
  logic [DW-1:0] res;

  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b0, div_q};
  assign res     = neg_q ? (~quo_q + DW'(1)) : quo_q;
  assign quotient_o = res[SampleW-1:0];
  assign done_o  = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= NW'(DW);
      end else if (run_q) begin
        cnt_q <= cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DW-1];
      quo_q <= dividend_i[DW-1] ? (~dividend_i + DW'(1)) : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      if (!diff[VW+1]) begin
        rem_q <= diff[VW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[VW-1:0];
        quo_q <= {quo_q[DW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/bad_ctrl.sv */
// ----------------------------------------------------------------------------
// Block average controller
// Sequences sample step, column store merge, divide and result hand-off.
// ----------------------------------------------------------------------------
module bad_ctrl import bad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bad_status_t st_i,
  output bad_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MERGE = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.step = 1'b1;
          if (st_i.colend) state_d = S_MERGE;
        end
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        if (st_i.last_row) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (st_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/core/bad_datapath.sv */
// ----------------------------------------------------------------------------
// Block average datapath
// Raster counters, row partial sums, column store, divider and output word.
// ----------------------------------------------------------------------------
module bad_datapath import bad_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bad_cmd_t                           cmd_i,
  output bad_status_t                        st_o,
  input  logic                               restart_i,
  input  logic [$clog2(MAX_COLS):0]          cols_i,
  input  logic [RowsW-1:0]                   rows_i,
  input  logic [$clog2(MAX_FACTOR):0]        rf_i,
  input  logic [$clog2(MAX_FACTOR):0]        cf_i,
  input  logic [SampleW-1:0]                 sample_i,
  input  logic                               sample_valid_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [SampleW-1:0]                 average_o,
  output logic                               average_valid_o,
  output logic                               end_of_out_row_o,
  output logic                               end_of_frame_o
);

  localparam int CW   = $clog2(MAX_COLS) + 1;
  localparam int JW   = $clog2(MAX_COLS);
  localparam int FW   = $clog2(MAX_FACTOR);
  localparam int PCW  = FW + 1;
  localparam int CNTW = 2 * FW + 1;
  localparam int SUMW = SampleW + 2 * FW;
  localparam int RW   = RowsW + 1;

  logic [CW-1:0]   col_pos_q, win_start_q;
  logic [RowsW-1:0] row_pos_q;
  logic [RW-1:0]   band_start_q;
  logic [JW-1:0]   jp_q, addr_q;
  logic [FW-1:0]   cin_q, rin_q;
  logic signed [SUMW-1:0] psum_q, pend_sum_q, ps;
  logic [PCW-1:0]  pcnt_q, pend_cnt_q, pc;
  logic            first_q, last_q, eor_q, eof_q;
  logic            res_valid_q, res_eor_q, res_eof_q;

  logic [31:0] c32, r32, cf32, rf32, ws32, bs32;
  logic        in_frame, colend, rowlast;

  logic [SUMW+CNTW-1:0] mem [MAX_COLS];
  logic [SUMW+CNTW-1:0] rd_q;
  logic signed [SUMW-1:0] new_sum;
  logic [CNTW-1:0] new_cnt;

  logic              div_done;
  logic [SampleW-1:0] quo;

  logic              ovalid_q, oaval_q, oeor_q, oeof_q;
  logic [SampleW-1:0] oavg_q;

  assign c32  = 32'(cols_i);
  assign r32  = 32'(rows_i);
  assign cf32 = 32'(cf_i);
  assign rf32 = 32'(rf_i);
  assign ws32 = 32'(win_start_q);
  assign bs32 = 32'(band_start_q);

  assign in_frame = (ws32 + cf32 <= c32) && (bs32 + rf32 <= r32);
  assign colend   = in_frame && (32'(cin_q) >= cf32 - 32'd1);
  assign rowlast  = 32'(rin_q) >= rf32 - 32'd1;

  assign ps = sample_valid_i ? psum_q + SUMW'(signed'(sample_i)) : psum_q;
  assign pc = sample_valid_i ? pcnt_q + PCW'(1) : pcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q    <= '0;
      row_pos_q    <= '0;
      win_start_q  <= '0;
      band_start_q <= '0;
      jp_q         <= '0;
      cin_q        <= '0;
      rin_q        <= '0;
      psum_q       <= '0;
      pcnt_q       <= '0;
    end else if (restart_i) begin
      col_pos_q    <= '0;
      row_pos_q    <= '0;
      win_start_q  <= '0;
      band_start_q <= '0;
      jp_q         <= '0;
      cin_q        <= '0;
      rin_q        <= '0;
      psum_q       <= '0;
      pcnt_q       <= '0;
    end else if (cmd_i.step) begin
      if (in_frame) begin
        if (colend) begin
          psum_q      <= '0;
          pcnt_q      <= '0;
          cin_q       <= '0;
          win_start_q <= win_start_q + CW'(cf_i);
          jp_q        <= jp_q + JW'(1);
        end else begin
          psum_q <= ps;
          pcnt_q <= pc;
          cin_q  <= cin_q + FW'(1);
        end
      end
      if (32'(col_pos_q) >= c32 - 32'd1) begin
        col_pos_q   <= '0;
        cin_q       <= '0;
        psum_q      <= '0;
        pcnt_q      <= '0;
        win_start_q <= '0;
        jp_q        <= '0;
        if (rowlast) begin
          rin_q        <= '0;
          band_start_q <= band_start_q + RW'(rf_i);
        end else begin
          rin_q <= rin_q + FW'(1);
        end
        if (32'(row_pos_q) >= r32 - 32'd1) begin
          row_pos_q    <= '0;
          rin_q        <= '0;
          band_start_q <= '0;
        end else begin
          row_pos_q <= row_pos_q + RowsW'(1);
        end
      end else begin
        col_pos_q <= col_pos_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      rd_q       <= mem[jp_q];
      addr_q     <= jp_q;
      pend_sum_q <= ps;
      pend_cnt_q <= pc;
      first_q    <= (rin_q == '0);
      last_q     <= rowlast;
      eor_q      <= ws32 + 2 * cf32 > c32;
      eof_q      <= (ws32 + 2 * cf32 > c32) && (bs32 + 2 * rf32 > r32);
    end
    if (cmd_i.merge) begin
      mem[addr_q] <= {new_sum, new_cnt};
      res_valid_q <= (new_cnt != '0);
      res_eor_q   <= eor_q;
      res_eof_q   <= eof_q;
    end
  end

  assign new_sum = first_q ? pend_sum_q : signed'(rd_q[SUMW+CNTW-1:CNTW]) + pend_sum_q;
  assign new_cnt = first_q ? CNTW'(pend_cnt_q) : rd_q[CNTW-1:0] + CNTW'(pend_cnt_q);

  bad_div #(.DW(SUMW), .VW(CNTW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (new_sum),
    .divisor_i  (new_cnt),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      oavg_q  <= res_valid_q ? quo : '0;
      oaval_q <= res_valid_q;
      oeor_q  <= res_eor_q;
      oeof_q  <= res_eof_q;
    end
  end

  assign st_o.colend   = colend;
  assign st_o.last_row = last_q;
  assign st_o.div_done = div_done;
  assign st_o.out_free = !ovalid_q || out_ready_i;

  assign out_valid_o      = ovalid_q;
  assign average_o        = oavg_q;
  assign average_valid_o  = oaval_q;
  assign end_of_out_row_o = oeor_q;
  assign end_of_frame_o   = oeof_q;

endmodule

/* rtl/core/block_average_downsampler.sv */
// Words inside a window row are taken back to back; a word that closes a window
// column is followed by a merge (column store read, then merge write) first.
// A word that closes a window passes through merge, divide and output states before its
// result is presented; the next word is taken once the result is loaded, and loading
// waits while a previous result is not yet taken by m_axis_tready; one word in flight at a time.
// Reset: async, active low; clears counters, sums, handshakes; column store unreset.
// ----------------------------------------------------------------------------
// Block average downsampler top level
// Block mean of valid samples over row_factor x col_factor windows.
// ----------------------------------------------------------------------------
`include "block_average_downsampler_defines.svh"
module block_average_downsampler import bad_pkg::*; #(
  parameter int MAX_COLS   = 4096,
  parameter int MAX_FACTOR = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SampleW-1:0]   s_axis_tdata,   // sample
  input  logic                 s_axis_tuser,   // sample_valid
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SampleW-1:0]   m_axis_tdata,   // average
  output logic [1:0]           m_axis_tuser,   // average_valid, end_of_frame
  output logic                 m_axis_tlast,   // end_of_out_row
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int CW  = $clog2(MAX_COLS) + 1;
  localparam int FW1 = $clog2(MAX_FACTOR) + 1;

  logic [ColsW-1:0] cols_q;
  logic [RowsW-1:0] rows_q;
  logic [FactW-1:0] rf_q, cf_q;
  logic             wr;
  logic [CW-1:0]    cols_e;
  logic [RowsW-1:0] rows_e;
  logic [FW1-1:0]   rf_e, cf_e;
  bad_cmd_t         cmd;
  bad_status_t      st;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsW'(1024);
      rows_q <= RowsW'(1024);
      rf_q   <= FactW'(1);
      cf_q   <= FactW'(1);
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_IMAGE_COLS: cols_q <= pwdata[ColsW-1:0];
        REG_IMAGE_ROWS: rows_q <= pwdata[RowsW-1:0];
        REG_ROW_FACTOR: rf_q   <= pwdata[FactW-1:0];
        REG_COL_FACTOR: cf_q   <= pwdata[FactW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_IMAGE_COLS: prdata = 32'(cols_q);
      REG_IMAGE_ROWS: prdata = 32'(rows_q);
      REG_ROW_FACTOR: prdata = 32'(rf_q);
      REG_COL_FACTOR: prdata = 32'(cf_q);
      default:        prdata = '0;
    endcase
  end

  assign cols_e = (cols_q == '0) ? CW'(1) :
                  (32'(cols_q) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_q);
  assign rows_e = (rows_q == '0) ? RowsW'(1) : rows_q;
  assign rf_e   = (rf_q == '0) ? FW1'(1) :
                  (32'(rf_q) > 32'(MAX_FACTOR)) ? FW1'(MAX_FACTOR) : FW1'(rf_q);
  assign cf_e   = (cf_q == '0) ? FW1'(1) :
                  (32'(cf_q) > 32'(MAX_FACTOR)) ? FW1'(MAX_FACTOR) : FW1'(cf_q);

  bad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  bad_datapath #(.MAX_COLS(MAX_COLS), .MAX_FACTOR(MAX_FACTOR)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .st_o             (st),
    .restart_i        (wr),
    .cols_i           (cols_e),
    .rows_i           (rows_e),
    .rf_i             (rf_e),
    .cf_i             (cf_e),
    .sample_i         (s_axis_tdata),
    .sample_valid_i   (s_axis_tuser),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .average_o        (m_axis_tdata),
    .average_valid_o  (m_axis_tuser[0]),
    .end_of_out_row_o (m_axis_tlast),
    .end_of_frame_o   (m_axis_tuser[1])
  );

  `BAD_ASSERT(a_nodata_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)
  `BAD_ASSERT(a_eof_eor, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
  `BAD_ASSERT_NEXT(a_merge_busy, clk_i, rst_ni, cmd.step && st.colend, !s_axis_tready)

endmodule

/* tb/sv/block_average_downsampler_tb.sv */
// ----------------------------------------------------------------------------
// Block average downsampler testbench
// Streams samples through a series of window and frame settings and checks
// every averaged word against a cycle-free window-mean predictor.
// ----------------------------------------------------------------------------
module block_average_downsampler_tb import bad_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCOLS = 4096;
  localparam int NFACT = 16;
  localparam int WDOG  = 3000;
  localparam int SETTLE = 80;
  localparam int NWORDS = 1100;

  typedef struct {
    logic [31:0] mean;
    bit          mean_ok;
    bit          row_end;
    bit          frame_end;
  } avg_word_t;

  class window_mean_sb;
    int unsigned cols, rows, rf, cf;
    int unsigned cpos, rpos, cwin, rwin;
    longint      psum;
    int unsigned pcnt;
    longint      csum [NCOLS];
    int unsigned ccnt [NCOLS];
    avg_word_t   pending_means[$];
    int          errors, results;

    function new();
      cols = 1024; rows = 1024; rf = 1; cf = 1;
      restart();
    endfunction

    function void restart();
      cpos = 0; rpos = 0; cwin = 0; rwin = 0; psum = 0; pcnt = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_IMAGE_COLS: begin
          cols = v[12:0];
          if (cols == 0) cols = 1;
          if (cols > NCOLS) cols = NCOLS;
        end
        REG_IMAGE_ROWS: begin
          rows = v[15:0];
          if (rows == 0) rows = 1;
        end
        REG_ROW_FACTOR: begin
          rf = v[4:0];
          if (rf == 0) rf = 1;
          if (rf > NFACT) rf = NFACT;
        end
        default: begin
          cf = v[4:0];
          if (cf == 0) cf = 1;
          if (cf > NFACT) cf = NFACT;
        end
      endcase
      restart();
    endfunction

    function void note_sample(logic [31:0] d, bit ok);
      int unsigned ncol2, nrow2, jp;
      longint      m;
      avg_word_t   w;
      ncol2 = cols / cf;
      nrow2 = rows / rf;
      if (cpos < ncol2 * cf && rpos < nrow2 * rf) begin
        if (ok) begin
          psum += longint'($signed(d));
          pcnt++;
        end
        if (cwin >= cf - 1) begin
          jp = cpos / cf;
          if (rwin == 0) begin
            csum[jp] = psum;
            ccnt[jp] = pcnt;
          end else begin
            csum[jp] += psum;
            ccnt[jp] += pcnt;
          end
          psum = 0; pcnt = 0; cwin = 0;
          if (rwin >= rf - 1) begin
            m = 0;
            if (ccnt[jp] > 0) m = csum[jp] / longint'(ccnt[jp]);
            w.mean = m[31:0];
            w.mean_ok = ccnt[jp] > 0;
            w.row_end = jp == ncol2 - 1;
            w.frame_end = w.row_end && rpos == nrow2 * rf - 1;
            pending_means = {pending_means, w};
          end
        end else begin
          cwin++;
        end
      end
      if (cpos >= cols - 1) begin
        cpos = 0; cwin = 0; psum = 0; pcnt = 0;
        rwin = (rwin >= rf - 1) ? 0 : rwin + 1;
        if (rpos >= rows - 1) begin
          rpos = 0; rwin = 0;
        end else begin
          rpos++;
        end
      end else begin
        cpos++;
      end
    endfunction

    function void check_mean(logic [31:0] d, bit ok, bit re, bit fe);
      avg_word_t w;
      results++;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: mean %h ok %0b", d, ok);
        return;
      end
      w = pending_means.pop_front();
      if (w.mean !== d || w.mean_ok !== ok || w.row_end !== re || w.frame_end !== fe) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp mean %h ok %0b eor %0b eof %0b, got %h %0b %0b %0b",
                   w.mean, w.mean_ok, w.row_end, w.frame_end, d, ok, re, fe);
      end
    endfunction
  endclass

  logic        clk_i = 0, rst_ni = 0;
  logic        s_axis_tvalid = 0, s_axis_tuser = 0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tready;
  logic        m_axis_tvalid, m_axis_tlast;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;   // average
  logic [1:0]  m_axis_tuser;   // average_valid, end_of_frame
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  window_mean_sb sb = new();
  bit idle_on = 1;
  int words_in, phases, idle_cycles;

  block_average_downsampler uut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      sb.check_mean(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]);
  end

  always @(negedge clk_i) begin
    if (rst_ni && idle_on && m_axis_tready && $urandom_range(0, 9) == 0) begin
      m_axis_tready = 0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    m_axis_tready = 1;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WDOG) begin
      $display("block_average_downsampler_tb: errors");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel = 1; pwrite = 1; penable = 0; paddr = {idx, 2'b00}; pwdata = v;
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic send_sample(logic [31:0] d, bit ok);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_axis_tvalid = 0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid = 1; s_axis_tdata = d; s_axis_tuser = ok;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(d, ok);
    words_in++;
    @(negedge clk_i);
    s_axis_tvalid = 0;
  endtask

  // wait for every expected word, then let a window-closing word finish
  task automatic drain();
    while (sb.pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(int c, int r, int rfv, int cfv);
    drain();
    reg_write(REG_IMAGE_COLS, c);
    reg_write(REG_IMAGE_ROWS, r);
    reg_write(REG_ROW_FACTOR, rfv);
    reg_write(REG_COL_FACTOR, cfv);
    phases++;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_words(int n);
    repeat (n) send_sample(rand_sample(), $urandom_range(0, 4) != 0);
  endtask

  initial begin
    logic [31:0] corner[8];
    int c, r, nitems;
    corner = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff,
               32'h0001_0000, 32'hffff_0000, 32'haaaa_aaaa, 32'h5555_5555};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset settings: 1x1 windows, every valid word averages itself
    foreach (corner[i]) send_sample(corner[i], 1);
    foreach (corner[i]) send_sample(corner[i], 0);

    configure(2, 2, 2, 2);                 // each window sums repeated max magnitudes
    send_sample(32'h7fff_ffff, 1); send_sample(32'h7fff_ffff, 1);
    send_sample(32'h7fff_ffff, 1); send_sample(32'h8000_0000, 0);
    send_sample(32'h8000_0000, 1); send_sample(32'h8000_0000, 1);
    send_sample(32'h8000_0000, 0); send_sample(32'h8000_0000, 1);

    configure(0, 0, 0, 0);                 // zeros act as one
    run_words(4);
    configure(4, 3, 31, 20);               // frame smaller than one window
    run_words(12);
    configure(16, 16, 16, 16);
    run_words(256);
    configure(12, 65535, 3, 4);
    run_words(120);
    configure(7, 5, 2, 3);
    run_words(70);

    while (words_in < NWORDS) begin
      if (words_in > 1000) idle_on = 0;
      c = $urandom_range(1, 20);
      r = $urandom_range(1, 12);
      configure(c, r, $urandom_range(1, 5), $urandom_range(1, 5));
      nitems = c * r * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) nitems = $urandom_range(1, c * r);
      if (nitems > NWORDS - words_in) nitems = NWORDS - words_in;
      run_words(nitems);
    end

    drain();
    $display("%0d samples over %0d window settings, %0d averages checked",
             words_in, phases, sb.results);
    if (sb.errors == 0 && sb.pending_means.size() == 0)
      $display("block_average_downsampler_tb: clean");
    else
      $display("block_average_downsampler_tb: errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/bad_pkg.sv
rtl/core/bad_div.sv
rtl/core/bad_ctrl.sv
rtl/core/bad_datapath.sv
rtl/core/block_average_downsampler.sv
tb/sv/block_average_downsampler_tb.sv
